@@ src/acs_pkg.sv @@
// ============================================================================
// acs_pkg: shared definitions for the adaptive categorical sampler
// Level count, field widths, operation and register codes, and reset values.
// ============================================================================
`default_nettype none

package acs_pkg;

    // Number of discrete levels held by the sampler (2 to 4).
    localparam int NUM_LEVELS = 3;

    // Address width of the per-level memories.
    localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    // Fixed field widths.
    localparam int LEVEL_W    = 2;
    localparam int VALUE_W    = 16;
    localparam int PROB_W     = 16;
    localparam int CNT_W      = 16;
    localparam int TOL_W      = 15;
    localparam int ALPHA_W    = 16;
    localparam int DRAW_W     = 16;
    localparam int KIND_W     = 2;

    // Running sums and the total count stay below 4 * 2^16.
    localparam int TOT_W      = 18;
    // Divider: partial remainder, quotient and step count.
    localparam int REM_W      = TOT_W + 1;
    localparam int QUO_W      = PROB_W + 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    // Products of the blend: 17 x 16 and 16 x 17 bits.
    localparam int PROD_W     = QUO_W + PROB_W;

    // Configuration port.
    localparam int NUM_VALUE_REGS = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_VALUE_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_VALUE_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_VALUE_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_VALUE_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_ALPHA  = 3'd5;

    // Operation codes carried by the kind field.
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OBSERVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd3;

    // Reset values.
    localparam logic signed [VALUE_W-1:0] LEVEL_VALUE_RESET [NUM_VALUE_REGS] =
        '{-16'sd4407, 16'sd10395, 16'sd16384, 16'sd0};
    localparam logic [TOL_W-1:0]   TOL_RESET   = 15'd164;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd43909;
    localparam logic [PROB_W-1:0]  PROB_RESET  = PROB_W'(32'd65536 / NUM_LEVELS);

    localparam logic [LVL_W-1:0]   LAST_IDX    = LVL_W'(NUM_LEVELS - 1);
    localparam logic [LVL_W-1:0]   SAMPLE_LAST = LVL_W'(NUM_LEVELS - 2);
    localparam logic [LEVEL_W-1:0] LAST_LEVEL  = LEVEL_W'(NUM_LEVELS - 1);

endpackage

`default_nettype wire

@@ src/acs_ram.sv @@
// ============================================================================
// acs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
`default_nettype none

module acs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/adaptive_categorical_sampler.sv @@
// A sample walks the levels up to the chosen one, an observe stops at the first matching
// level, and an update makes two passes over all levels.
// The second update pass runs the 17-step restoring divider once per level.
// One item is in work at a time; the next is taken once the result is in the output register.
// Reset (rst_n low, asynchronous) restores control and configuration registers, uniform probabilities, zero counts.
// ============================================================================
// adaptive_categorical_sampler: inverse-CDF categorical sampler
// Keeps a probability and occurrence count per level in two small RAMs,
// samples by walking the cumulative sum, counts matching observations, clears the counts and
// blends probabilities towards observed frequencies.
// ============================================================================
`default_nettype none

module adaptive_categorical_sampler (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Input channel
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic        [acs_pkg::KIND_W-1:0]      kind,
    input  wire logic        [acs_pkg::DRAW_W-1:0]      random_draw,
    input  wire logic signed [acs_pkg::VALUE_W-1:0]     observed_value,
    // Output channel
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed      [acs_pkg::VALUE_W-1:0]     chosen_value,
    output logic             [acs_pkg::LEVEL_W-1:0]     chosen_level,
    output logic                                        matched,
    // Configuration port
    input  wire logic                                   cfg_we,
    input  wire logic        [acs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [acs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SRD  = 4'd1;
    localparam logic [3:0] ST_SEV  = 4'd2;
    localparam logic [3:0] ST_OCMP = 4'd3;
    localparam logic [3:0] ST_OWR  = 4'd4;
    localparam logic [3:0] ST_TRD  = 4'd5;
    localparam logic [3:0] ST_TACC = 4'd6;
    localparam logic [3:0] ST_URD  = 4'd7;
    localparam logic [3:0] ST_ULD  = 4'd8;
    localparam logic [3:0] ST_UDIV = 4'd9;
    localparam logic [3:0] ST_UMUL = 4'd10;
    localparam logic [3:0] ST_UADD = 4'd11;
    localparam logic [3:0] ST_FIN  = 4'd12;

    // Control and configuration state
    logic [3:0]                          state_reg, state_next;
    logic [acs_pkg::LVL_W-1:0]           idx_reg, idx_next;
    logic [acs_pkg::STEP_W-1:0]          step_reg, step_next;
    logic [acs_pkg::NUM_LEVELS-1:0]      prob_vld_reg, prob_vld_next;
    logic [acs_pkg::NUM_LEVELS-1:0]      cnt_vld_reg, cnt_vld_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [acs_pkg::VALUE_W-1:0]  level_value_reg [acs_pkg::NUM_VALUE_REGS];
    logic signed [acs_pkg::VALUE_W-1:0]  level_value_next [acs_pkg::NUM_VALUE_REGS];
    logic [acs_pkg::TOL_W-1:0]           tol_reg, tol_next;
    logic [acs_pkg::ALPHA_W-1:0]         alpha_reg, alpha_next;

    // Payload and datapath registers
    logic [acs_pkg::KIND_W-1:0]          kind_reg, kind_next;
    logic [acs_pkg::DRAW_W-1:0]          draw_reg, draw_next;
    logic signed [acs_pkg::VALUE_W-1:0]  obs_reg, obs_next;
    logic [acs_pkg::TOT_W-1:0]           sum_reg, sum_next;
    logic [acs_pkg::REM_W-1:0]           rem_reg, rem_next;
    logic [acs_pkg::QUO_W-1:0]           quo_reg, quo_next;
    logic [acs_pkg::CNT_W-1:0]           cnt_cur_reg, cnt_cur_next;
    logic [acs_pkg::PROB_W-1:0]          prob_cur_reg, prob_cur_next;
    logic [acs_pkg::PROD_W-1:0]          prod_a_reg, prod_a_next;
    logic [acs_pkg::PROD_W-1:0]          prod_b_reg, prod_b_next;
    logic [acs_pkg::LEVEL_W-1:0]         res_level_reg, res_level_next;
    logic                                res_match_reg, res_match_next;
    logic signed [acs_pkg::VALUE_W-1:0]  chosen_value_reg, chosen_value_next;
    logic [acs_pkg::LEVEL_W-1:0]         chosen_level_reg, chosen_level_next;
    logic                                matched_reg, matched_next;

    // Memory ports
    logic                                prob_we, cnt_we;
    logic [acs_pkg::PROB_W-1:0]          prob_wdata, prob_rdata;
    logic [acs_pkg::CNT_W-1:0]           cnt_wdata, cnt_rdata;

    // Datapath helpers
    logic [acs_pkg::PROB_W-1:0]          prob_rd;
    logic [acs_pkg::CNT_W-1:0]           cnt_rd;
    logic signed [acs_pkg::VALUE_W:0]    diff;
    logic [acs_pkg::VALUE_W:0]           abs_diff;
    logic [acs_pkg::TOT_W-1:0]           run_sum;
    logic                                div_ge;
    logic [acs_pkg::REM_W-1:0]           rem_sub;
    logic [acs_pkg::QUO_W-1:0]           freq;
    logic [acs_pkg::QUO_W-1:0]           one_minus_alpha;
    logic [acs_pkg::PROD_W:0]            blend_sum;

    acs_ram #(
        .WIDTH (acs_pkg::PROB_W),
        .DEPTH (acs_pkg::NUM_LEVELS)
    ) u_prob_ram (
        .clk   (clk),
        .we    (prob_we),
        .waddr (idx_reg),
        .wdata (prob_wdata),
        .raddr (idx_reg),
        .rdata (prob_rdata)
    );

    acs_ram #(
        .WIDTH (acs_pkg::CNT_W),
        .DEPTH (acs_pkg::NUM_LEVELS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (idx_reg),
        .wdata (cnt_wdata),
        .raddr (idx_reg),
        .rdata (cnt_rdata)
    );

    // Entries never written since reset (count entries also since a clear) read as their reset value.
    assign prob_rd = prob_vld_reg[idx_reg] ? prob_rdata : acs_pkg::PROB_RESET;
    assign cnt_rd  = cnt_vld_reg[idx_reg] ? cnt_rdata : '0;

    assign diff = {obs_reg[acs_pkg::VALUE_W-1], obs_reg}
                - {level_value_reg[acs_pkg::LEVEL_W'(idx_reg)][acs_pkg::VALUE_W-1],
                   level_value_reg[acs_pkg::LEVEL_W'(idx_reg)]};
    assign abs_diff = diff[acs_pkg::VALUE_W] ? 17'(-diff) : 17'(diff);

    assign run_sum = sum_reg + acs_pkg::TOT_W'(prob_rd);

    assign div_ge  = rem_reg >= acs_pkg::REM_W'(sum_reg);
    assign rem_sub = div_ge ? (rem_reg - acs_pkg::REM_W'(sum_reg)) : rem_reg;

    assign freq            = (cnt_cur_reg == '0) ? '0 : quo_reg;
    assign one_minus_alpha = 17'h10000 - acs_pkg::QUO_W'(alpha_reg);
    assign blend_sum       = (acs_pkg::PROD_W + 1)'(prod_a_reg)
                           + (acs_pkg::PROD_W + 1)'(prod_b_reg);

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        step_next         = step_reg;
        prob_vld_next     = prob_vld_reg;
        cnt_vld_next      = cnt_vld_reg;
        out_valid_next    = out_valid_reg;
        level_value_next  = level_value_reg;
        tol_next          = tol_reg;
        alpha_next        = alpha_reg;
        kind_next         = kind_reg;
        draw_next         = draw_reg;
        obs_next          = obs_reg;
        sum_next          = sum_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        cnt_cur_next      = cnt_cur_reg;
        prob_cur_next     = prob_cur_reg;
        prod_a_next       = prod_a_reg;
        prod_b_next       = prod_b_reg;
        res_level_next    = res_level_reg;
        res_match_next    = res_match_reg;
        chosen_value_next = chosen_value_reg;
        chosen_level_next = chosen_level_reg;
        matched_next      = matched_reg;
        prob_we           = 1'b0;
        cnt_we            = 1'b0;
        prob_wdata        = (blend_sum[acs_pkg::PROD_W:acs_pkg::PROB_W+acs_pkg::PROB_W] != '0)
                          ? 16'hFFFF : blend_sum[acs_pkg::PROB_W+acs_pkg::PROB_W-1:acs_pkg::PROB_W];
        cnt_wdata         = (cnt_rd == 16'hFFFF) ? cnt_rd : cnt_rd + 16'd1;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                acs_pkg::REG_LEVEL_VALUE_0: level_value_next[0] = cfg_data;
                acs_pkg::REG_LEVEL_VALUE_1: level_value_next[1] = cfg_data;
                acs_pkg::REG_LEVEL_VALUE_2: level_value_next[2] = cfg_data;
                acs_pkg::REG_LEVEL_VALUE_3: level_value_next[3] = cfg_data;
                acs_pkg::REG_MATCH_TOL:     tol_next = cfg_data[acs_pkg::TOL_W-1:0];
                acs_pkg::REG_UPDATE_ALPHA:  alpha_next = cfg_data;
                default:                    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next      = kind;
                    draw_next      = random_draw;
                    obs_next       = observed_value;
                    idx_next       = '0;
                    sum_next       = '0;
                    res_level_next = '0;
                    res_match_next = 1'b0;
                    case (kind)
                        acs_pkg::KIND_SAMPLE:  state_next = ST_SRD;
                        acs_pkg::KIND_OBSERVE: state_next = ST_OCMP;
                        acs_pkg::KIND_CLEAR:
                        begin
                            cnt_vld_next = '0;
                            state_next   = ST_FIN;
                        end
                        acs_pkg::KIND_UPDATE:  state_next = ST_TRD;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end

            // Sample: wait for the probability read, then extend the running sum.
            ST_SRD:
            begin
                state_next = ST_SEV;
            end

            ST_SEV:
            begin
                sum_next = run_sum;
                if (acs_pkg::TOT_W'(draw_reg) <= run_sum)
                begin
                    res_level_next = acs_pkg::LEVEL_W'(idx_reg);
                    state_next     = ST_FIN;
                end
                else if (idx_reg == acs_pkg::SAMPLE_LAST)
                begin
                    res_level_next = acs_pkg::LAST_LEVEL;
                    state_next     = ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SRD;
                end
            end

            // Observe: one level compared per cycle; the count read of the
            // matching level is already under way when the match is seen.
            ST_OCMP:
            begin
                if (abs_diff < (acs_pkg::VALUE_W + 1)'(tol_reg))
                begin
                    res_level_next = acs_pkg::LEVEL_W'(idx_reg);
                    res_match_next = 1'b1;
                    state_next     = ST_OWR;
                end
                else if (idx_reg == acs_pkg::LAST_IDX)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_OWR:
            begin
                cnt_we                = 1'b1;
                cnt_vld_next[idx_reg] = 1'b1;
                state_next            = ST_FIN;
            end

            // Update, first pass: total of all counts.
            ST_TRD:
            begin
                state_next = ST_TACC;
            end

            ST_TACC:
            begin
                sum_next = sum_reg + acs_pkg::TOT_W'(cnt_rd);
                if (idx_reg == acs_pkg::LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_URD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TRD;
                end
            end

            // Update, second pass: per level divide, blend and write back.
            ST_URD:
            begin
                state_next = ST_ULD;
            end

            ST_ULD:
            begin
                cnt_cur_next  = cnt_rd;
                prob_cur_next = prob_rd;
                rem_next      = acs_pkg::REM_W'(cnt_rd);
                quo_next      = '0;
                step_next     = '0;
                state_next    = ST_UDIV;
            end

            // Restoring division of count * 2^16 by the total, one quotient bit per cycle.
            ST_UDIV:
            begin
                quo_next = {quo_reg[acs_pkg::QUO_W-2:0], div_ge};
                rem_next = {rem_sub[acs_pkg::REM_W-2:0], 1'b0};
                if (step_reg == acs_pkg::STEP_W'(acs_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_UMUL;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            ST_UMUL:
            begin
                prod_a_next = acs_pkg::PROD_W'(one_minus_alpha) * acs_pkg::PROD_W'(prob_cur_reg);
                prod_b_next = acs_pkg::PROD_W'(alpha_reg) * acs_pkg::PROD_W'(freq);
                state_next  = ST_UADD;
            end

            ST_UADD:
            begin
                prob_we                = 1'b1;
                prob_vld_next[idx_reg] = 1'b1;
                if (idx_reg == acs_pkg::LAST_IDX)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_URD;
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    chosen_value_next = (kind_reg == acs_pkg::KIND_SAMPLE)
                                      ? level_value_reg[res_level_reg] : '0;
                    chosen_level_next = res_level_reg;
                    matched_next      = res_match_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            step_reg      <= '0;
            prob_vld_reg  <= '0;
            cnt_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < acs_pkg::NUM_VALUE_REGS; i++)
            begin
                level_value_reg[i] <= acs_pkg::LEVEL_VALUE_RESET[i];
            end
            tol_reg       <= acs_pkg::TOL_RESET;
            alpha_reg     <= acs_pkg::ALPHA_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            step_reg        <= step_next;
            prob_vld_reg    <= prob_vld_next;
            cnt_vld_reg     <= cnt_vld_next;
            out_valid_reg   <= out_valid_next;
            level_value_reg <= level_value_next;
            tol_reg         <= tol_next;
            alpha_reg       <= alpha_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        draw_reg         <= draw_next;
        obs_reg          <= obs_next;
        sum_reg          <= sum_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        cnt_cur_reg      <= cnt_cur_next;
        prob_cur_reg     <= prob_cur_next;
        prod_a_reg       <= prod_a_next;
        prod_b_reg       <= prod_b_next;
        res_level_reg    <= res_level_next;
        res_match_reg    <= res_match_next;
        chosen_value_reg <= chosen_value_next;
        chosen_level_reg <= chosen_level_next;
        matched_reg      <= matched_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign chosen_value = chosen_value_reg;
    assign chosen_level = chosen_level_reg;
    assign matched      = matched_reg;

endmodule

`default_nettype wire

@@ src/acs_checker.sv @@
// ============================================================================
// acs_checker: port-level assertions for the adaptive categorical sampler
// Watches the handshakes and result fields and is bound to the top level.
// ============================================================================
`default_nettype none

module acs_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [acs_pkg::VALUE_W-1:0]  chosen_value,
    input wire logic        [acs_pkg::LEVEL_W-1:0]  chosen_level,
    input wire logic                                matched
);

    // A result held back by the consumer stays put until its transaction completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(chosen_value)
                                    && $stable(chosen_level) && $stable(matched))
        else $error("result changed while waiting for out_ready");

    // No item is accepted in the cycle right after an accepted one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    // A matched observation never carries a sampled value.
    a_match_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> chosen_value == '0)
        else $error("observe result carries a nonzero value");

    // Reported levels always exist.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> chosen_level <= acs_pkg::LAST_LEVEL)
        else $error("chosen_level beyond the last level");

endmodule

bind adaptive_categorical_sampler acs_checker u_acs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .chosen_value (chosen_value),
    .chosen_level (chosen_level),
    .matched      (matched)
);

`default_nettype wire
